>>> rtl/core/bmt_pkg.sv
package bmt_pkg;

   // Field widths of the request and response beats.
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned KEY_W   = 16;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned SUM_W   = 48;
   localparam int unsigned MEAN_W  = 32;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 48;

   // Shared divider: 48-bit dividend, 16-bit divisor, one quotient bit a cycle.
   localparam int unsigned DIV_W   = SUM_W;
   localparam int unsigned DSR_W   = 16;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

   // Register file.
   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_LIMIT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LIMIT   = 1'b1;
   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 16'd8000;
   localparam logic [LIMIT_W-1:0] KEY_LIMIT_RESET   = 16'd25600;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_QCOORD = 2'd1,
      ACT_QINDEX = 2'd2,
      ACT_FILL   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIV_ROW  = 2'd0,
      DIV_COL  = 2'd1,
      DIV_MEAN = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_row;
      logic        cap_col;
      logic        cap_idx;
      logic        mem_rd;
      logic        wr_add;
      logic        wr_fill;
      logic        wr_clear;
      logic        mark_miss;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       ranges_ok;
      logic       idx_ok;
      logic       div_done;
      logic       count_zero;
      logic       count_max;
      logic       sweep_last;
      logic       rsp_busy;
   } status_type;

endpackage

>>> rtl/core/binned_mean_table_2d.sv
// Beats are taken one at a time: a new beat is accepted only once the previous add, query or
// fill is through; out-of-range beats and empty bins end sooner. Every division runs on the
// shared 48-step restoring divider. Synchronous active-high reset restores the limits, then a
// clearing pass over all TABLE_SIZE*TABLE_SIZE bins runs during which no beat is accepted.
module binned_mean_table_2d
   import bmt_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // engine_speed[15:0], load_key[31:16], sample_value[63:32], fill_count[79:64],
   // row_index[83:80], col_index[87:84]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mean_value[31:0], sample_count[47:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // mean_valid[0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmt_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> rtl/core/bmt_divider.sv
module bmt_divider
   import bmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DSR_W:0]       trial;
   logic [DSR_W:0]       diff;

   // One restoring step: shift the next dividend bit into the remainder.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/bmt_datapath.sv
module bmt_datapath
   import bmt_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LIMIT_W-1:0]    csr_wdata,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int TOTAL = TABLE_SIZE * TABLE_SIZE;
   localparam int QW    = $clog2(TABLE_SIZE);
   localparam int AW    = $clog2(TOTAL);
   localparam int NW    = SPEED_W + QW + 1;
   localparam int ENT_W = SUM_W + COUNT_W;

   // Latched request fields.
   action_type          action_ff;
   logic [SPEED_W-1:0]  speed_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [COUNT_W-1:0]  fcount_ff;
   logic [INDEX_W-1:0]  ridx_ff, cidx_ff;
   logic                miss_ff;

   logic [LIMIT_W-1:0]  speed_limit_ff, key_limit_ff;
   logic [QW-1:0]       row_ff;
   logic [AW-1:0]       addr_ff;
   logic [AW-1:0]       sweep_ff;
   logic [ENT_W-1:0]    rd_data_ff;
   logic [ENT_W-1:0]    mem [TOTAL];

   logic [MEAN_W-1:0]   rsp_mean_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_valid_ff;
   logic                rsp_flag_ff;

   logic [DIV_W-1:0]    div_dividend, div_quotient;
   logic [DSR_W-1:0]    div_divisor;
   logic                div_done;
   logic [NW-1:0]       speed_scaled, key_scaled;

   logic [SUM_W-1:0]    rd_sum, sum_mag, sample_ext;
   logic [COUNT_W-1:0]  rd_count;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat;
   logic [MEAN_W-1:0]   mean_sat;
   logic                hit;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENT_W-1:0]    wr_data;

   assign rd_sum   = rd_data_ff[ENT_W-1:COUNT_W];
   assign rd_count = rd_data_ff[COUNT_W-1:0];
   assign sample_ext = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= action_type'(req_tuser);
         speed_ff  <= req_tdata[15:0];
         key_ff    <= req_tdata[31:16];
         sample_ff <= req_tdata[63:32];
         fcount_ff <= req_tdata[79:64];
         ridx_ff   <= req_tdata[83:80];
         cidx_ff   <= req_tdata[87:84];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff <= 1'b0;
      end else if (cmd.load_req) begin
         miss_ff <= 1'b0;
      end else if (cmd.mark_miss) begin
         miss_ff <= 1'b1;
      end
   end

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= SPEED_LIMIT_RESET;
         key_limit_ff   <= KEY_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
            CSR_KEY_LIMIT:   key_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Divider operands: scaled coordinate over limit, or bin sum magnitude over count.
   assign speed_scaled = NW'(speed_ff) * NW'(TABLE_SIZE);
   assign key_scaled   = NW'(key_ff) * NW'(TABLE_SIZE);
   assign sum_mag      = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_ROW: begin
            div_dividend = DIV_W'(speed_scaled);
            div_divisor  = speed_limit_ff;
         end
         DIV_COL: begin
            div_dividend = DIV_W'(key_scaled);
            div_divisor  = key_limit_ff;
         end
         default: begin
            div_dividend = sum_mag;
            div_divisor  = rd_count;
         end
      endcase
   end

   bmt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Bin address from division results or from explicit indexes.
   always_ff @(posedge clock) begin
      if (cmd.cap_row) begin
         row_ff <= div_quotient[QW-1:0];
      end
      if (cmd.cap_col) begin
         addr_ff <= AW'(row_ff) * AW'(TABLE_SIZE) + AW'(div_quotient[QW-1:0]);
      end else if (cmd.cap_idx) begin
         addr_ff <= AW'(ridx_ff) * AW'(TABLE_SIZE) + AW'(cidx_ff);
      end
   end

   // Sweep counter for the clearing pass and for fill.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.wr_clear || cmd.wr_fill) begin
         sweep_ff <= (sweep_ff == AW'(TOTAL - 1)) ? '0 : sweep_ff + 1'b1;
      end
   end

   // Saturating sum update.
   always_comb begin
      sum_wide = {rd_sum[SUM_W-1], rd_sum} + {sample_ext[SUM_W-1], sample_ext};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // Memory write selection.
   always_comb begin
      wr_en   = cmd.wr_clear || cmd.wr_fill || cmd.wr_add;
      wr_addr = sweep_ff;
      wr_data = '0;
      priority if (cmd.wr_add) begin
         wr_addr = addr_ff;
         wr_data = {sum_sat, rd_count + 1'b1};
      end else if (cmd.wr_fill) begin
         wr_data = {sample_ext, fcount_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // Signed mean from the magnitude quotient, clamped to 32 bits.
   always_comb begin
      if (rd_sum[SUM_W-1]) begin
         if (div_quotient > DIV_W'(64'h8000_0000)) begin
            mean_sat = {1'b1, {(MEAN_W-1){1'b0}}};
         end else begin
            mean_sat = ~div_quotient[MEAN_W-1:0] + 1'b1;
         end
      end else begin
         if (div_quotient > DIV_W'(64'h7FFF_FFFF)) begin
            mean_sat = {1'b0, {(MEAN_W-1){1'b1}}};
         end else begin
            mean_sat = div_quotient[MEAN_W-1:0];
         end
      end
   end

   assign hit = !miss_ff && (rd_count != '0);

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_mean_ff  <= hit ? mean_sat : '0;
         rsp_count_ff <= hit ? rd_count : '0;
         rsp_flag_ff  <= hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_mean_ff};
   assign rsp_tuser  = rsp_flag_ff;

   // Status toward the controller.
   assign status.action     = action_ff;
   assign status.ranges_ok  = (speed_ff < speed_limit_ff) && (key_ff < key_limit_ff);
   assign status.idx_ok     = (int'(ridx_ff) < TABLE_SIZE) && (int'(cidx_ff) < TABLE_SIZE);
   assign status.div_done   = div_done;
   assign status.count_zero = (rd_count == '0);
   assign status.count_max  = (rd_count == COUNT_MAX);
   assign status.sweep_last = (sweep_ff == AW'(TOTAL - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_tready;

endmodule

>>> rtl/core/bmt_ctrl.sv
module bmt_ctrl
   import bmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR     = 10'b00_0000_0001,
      ST_IDLE      = 10'b00_0000_0010,
      ST_DISPATCH  = 10'b00_0000_0100,
      ST_ROW_WAIT  = 10'b00_0000_1000,
      ST_COL_WAIT  = 10'b00_0001_0000,
      ST_READ      = 10'b00_0010_0000,
      ST_DECIDE    = 10'b00_0100_0000,
      ST_MEAN_WAIT = 10'b00_1000_0000,
      ST_RESP      = 10'b01_0000_0000,
      ST_FILL      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.div_sel = DIV_ROW;
      req_tready = 1'b0;
      unique case (state_ff)
         // Zero every bin after reset.
         ST_CLEAR: begin
            cmd.wr_clear = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.action)
               ACT_ADD, ACT_QCOORD: begin
                  if (status.ranges_ok) begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_ROW_WAIT;
                  end else if (status.action == ACT_ADD) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.mark_miss = 1'b1;
                     state_in      = ST_RESP;
                  end
               end
               ACT_QINDEX: begin
                  if (status.idx_ok) begin
                     cmd.cap_idx = 1'b1;
                     state_in    = ST_READ;
                  end else begin
                     cmd.mark_miss = 1'b1;
                     state_in      = ST_RESP;
                  end
               end
               default: state_in = ST_FILL;
            endcase
         end
         // Row bin found: start the column division at once.
         ST_ROW_WAIT: begin
            if (status.div_done) begin
               cmd.cap_row   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_COL;
               state_in      = ST_COL_WAIT;
            end
         end
         ST_COL_WAIT: begin
            cmd.div_sel = DIV_COL;
            if (status.div_done) begin
               cmd.cap_col = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.div_sel = DIV_MEAN;
            if (status.action == ACT_ADD) begin
               cmd.wr_add = !status.count_max;
               state_in   = ST_IDLE;
            end else if (status.count_zero) begin
               state_in = ST_RESP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            cmd.div_sel = DIV_MEAN;
            if (status.div_done) state_in = ST_RESP;
         end
         // Hold until the response register is free.
         ST_RESP: begin
            cmd.div_sel = DIV_MEAN;
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FILL: begin
            cmd.wr_fill = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
